### design/fpp_pkg.sv
// Package for the frame pacing predictor: function codes, phases, constants.
// No dependencies.
package fpp_pkg;

  // Ring size; a power of two, so the slot index is the low bits of the frame id.
  localparam int FRAME_SLOTS = 16;

  typedef enum logic [2:0] {
    FUNC_PREDICT = 3'd0,
    FUNC_WAKE    = 3'd1,
    FUNC_BEGIN   = 3'd2,
    FUNC_SUBMIT  = 3'd3,
    FUNC_INFO    = 3'd4
  } func_e;

  localparam logic [2:0] PH_CLEARED   = 3'd0;
  localparam logic [2:0] PH_PREDICTED = 3'd1;
  localparam logic [2:0] PH_INFO      = 3'd5;

  localparam logic [2:0] REG_PERIOD   = 3'd0;
  localparam logic [2:0] REG_OFFSET   = 3'd1;
  localparam logic [2:0] REG_CINIT    = 3'd2;
  localparam logic [2:0] REG_CMAX     = 3'd3;
  localparam logic [2:0] REG_ADJMISS  = 3'd4;
  localparam logic [2:0] REG_ADJNON   = 3'd5;
  localparam logic [2:0] REG_MARGIN   = 3'd6;

  localparam logic [29:0] HALF_MS = 30'd500000;
  localparam logic [3:0]  CLEAN_SLATE_PERIODS = 4'd10;

  // Operation codes for the shared adder/subtractor.
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1
  } alu_op_e;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    alu_op_e     op;
  } alu_req_t;

  // Signed "l within range of r" test: |l - r| < range, range > 0.
  function automatic logic within64(logic [63:0] l, logic [63:0] r, logic [29:0] range);
    logic [63:0] t;
    logic [63:0] rg;
    rg = {34'd0, range};
    t  = l - r + rg - 64'd1;
    return (range != '0) && (t < ((rg << 1) - 64'd1));
  endfunction

endpackage

### design/frame_pacing_predictor.sv
// Top level of the frame pacing predictor: registers, slot ring and sequencer.
// Depends on fpp_pkg and fpp_alu.
//
//  channel   | ports                               | handshake
//  config    | cfg_we_i, cfg_idx_i, cfg_data_i     | write when cfg_we_i high
//  command   | start_i, func_i .. reported_margin_i| taken when start_i & !busy_o
//  result    | done_o, accepted_o .. present_slop_o| one-cycle strobe on done_o
//
// A mark, info or unused-code item passes through S_MARK or S_INFO, then S_OUT,
// before done_o. A predict item scans the ring once for both searches, then
// runs S_TOTAL, S_LIMIT, S_FIN, S_WAKE and S_OUT on a clean slate, adds S_BASE,
// S_D and S_GAP when the first period step is already past the limit, and otherwise
// also S_DIV, the bit-serial remainder of the gap by the period, and S_STEP. S_TOTAL,
// S_LIMIT, S_D, S_GAP, S_STEP, S_FIN and S_WAKE each use the shared 64-bit adder.
// Reset clears slot ids and phases at once through flip-flops.
// The result cannot be stalled; busy_o stays high up to and including the done_o cycle.
module frame_pacing_predictor import fpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [29:0] cfg_data_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic [62:0] frame_id_i,
  input  logic [63:0] now_time_i,
  input  logic [63:0] actual_present_i,
  input  logic [63:0] earliest_present_i,
  input  logic [63:0] reported_margin_i,
  output logic        done_o,
  output logic        accepted_o,
  output logic [62:0] issued_frame_id_o,
  output logic [63:0] wake_up_time_o,
  output logic [63:0] desired_present_time_o,
  output logic [63:0] predicted_display_time_o,
  output logic [29:0] display_period_o,
  output logic [29:0] present_slop_o
);
  localparam int SW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CW = $clog2(FRAME_SLOTS + 1);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_MARK   = 14'b00000000000010,
    S_SRCH   = 14'b00000000000100,
    S_TOTAL  = 14'b00000000001000,
    S_LIMIT  = 14'b00000000010000,
    S_BASE   = 14'b00000000100000,
    S_D      = 14'b00000001000000,
    S_GAP    = 14'b00000010000000,
    S_DIV    = 14'b00000100000000,
    S_STEP   = 14'b00001000000000,
    S_FIN    = 14'b00010000000000,
    S_WAKE   = 14'b00100000000000,
    S_INFO   = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [29:0] period_q, offset_q, cinit_q, cmax_q, adjm_q, adjn_q, mtgt_q;
  logic [63:0] budget_q;
  logic [62:0] next_id_q;

  // slot ring
  logic [62:0] slot_id_q  [FRAME_SLOTS];
  logic [2:0]  slot_ph_q  [FRAME_SLOTS];
  logic [63:0] slot_des_q [FRAME_SLOTS];
  logic [63:0] slot_pd_q  [FRAME_SLOTS];
  logic [63:0] slot_ep_q  [FRAME_SLOTS];

  // item registers
  logic [2:0]  func_q;
  logic [62:0] fid_q;
  logic [63:0] now_q, act_q, ep_q, mar_q;

  // work registers
  logic [CW-1:0] cnt_q;
  logic          lp_f_q, lc_f_q;
  logic [SW-1:0] lp_q, lc_q;
  logic [63:0]   total_q, limit_q, base_q, d_q, gap_q, rem_q, acc_q;
  logic [6:0]    bit_q;
  logic          acc_q_ok;

  // outputs
  logic        done_q, acc_out_q;
  logic [62:0] oid_q;
  logic [63:0] wake_q, des_q, pd_q;
  logic [29:0] oper_q, oslop_q;

  // shared adder
  alu_req_t    alu_req;
  logic [63:0] alu_res;
  logic        alu_c;
  fpp_alu u_alu (.req_i(alu_req), .res_o(alu_res), .carry_o(alu_c));

  logic [SW-1:0]    fslot, nslot, sslot;
  logic [62:0]      sid;
  logic [63:0]      per1;
  logic [SW-1:0]    diff;
  logic [SW+29:0]   dprod;
  assign fslot = fid_q[SW-1:0];
  assign nslot = next_id_q[SW-1:0];
  assign sid   = next_id_q - {{(63-CW){1'b0}}, cnt_q};
  assign sslot = sid[SW-1:0];
  assign per1  = (period_q == '0) ? 64'd1 : {34'd0, period_q};
  // both frames lie within the last FRAME_SLOTS ids, so the id gap fits a slot index
  assign diff  = SW'(slot_id_q[lp_q] - slot_id_q[lc_q]);
  assign dprod = diff * period_q;

  logic search_ok;
  assign search_ok = ({{(63-CW){1'b0}}, cnt_q} <= next_id_q) && (cnt_q < CW'(FRAME_SLOTS));

  always_comb begin
    alu_req = '{a: '0, b: '0, op: ALU_ADD};
    unique case (state_q)
      S_TOTAL: alu_req = '{a: budget_q, b: {34'd0, mtgt_q}, op: ALU_ADD};
      S_LIMIT: alu_req = '{a: now_q, b: total_q, op: ALU_ADD};
      S_D:     alu_req = '{a: base_q, b: {34'd0, period_q}, op: ALU_ADD};
      S_GAP:   alu_req = '{a: limit_q, b: d_q, op: ALU_SUB};
      S_DIV:   alu_req = '{a: {rem_q[62:0], gap_q[63]}, b: per1, op: ALU_SUB};
      S_STEP:  alu_req = '{a: limit_q, b: acc_q, op: ALU_ADD};
      S_FIN:   alu_req = '{a: d_q, b: {34'd0, offset_q}, op: ALU_ADD};
      S_WAKE:  alu_req = '{a: d_q, b: total_q, op: ALU_SUB};
      default: ;
    endcase
  end

  logic id_match;
  assign id_match = (slot_id_q[fslot] == fid_q);

  // budget update for info
  logic [63:0] bud_new;
  logic        miss;
  logic [64:0] s_m, s_n;
  always_comb begin
    s_m  = {1'b0, budget_q} + {35'd0, adjm_q};
    s_n  = {1'b0, budget_q} + {35'd0, adjn_q};
    miss = (act_q > slot_des_q[fslot]) && !within64(act_q, slot_des_q[fslot], HALF_MS);
    bud_new = budget_q;
    priority if (miss) begin
      bud_new = s_m[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s_m[63:0];
      if (bud_new > {34'd0, cmax_q}) bud_new = {34'd0, cmax_q};
    end else if (!within64(mar_q, {34'd0, mtgt_q}, adjn_q)) begin
      if (mar_q > {34'd0, mtgt_q})
        bud_new = (budget_q > {34'd0, adjn_q}) ? budget_q - {34'd0, adjn_q} : 64'd0;
      else
        bud_new = s_n[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s_n[63:0];
    end else begin
      bud_new = budget_q;
    end
  end

  assign acc_q_ok = 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i && !busy_o) begin
        priority if (func_i == FUNC_PREDICT) state_d = S_SRCH;
        else if (func_i == FUNC_INFO) state_d = S_INFO;
        else state_d = S_MARK;
      end
      S_MARK:  state_d = S_OUT;
      S_INFO:  state_d = S_OUT;
      S_SRCH:  if (!search_ok || (lp_f_q && lc_f_q)) state_d = S_TOTAL;
      S_TOTAL: state_d = S_LIMIT;
      S_LIMIT: state_d = (!lp_f_q && !lc_f_q) ? S_FIN : S_BASE;
      S_BASE:  state_d = S_D;
      S_D:     state_d = S_GAP;
      S_GAP:   state_d = (d_q > limit_q) ? S_FIN : S_DIV;
      S_DIV:   if (bit_q == 7'd0) state_d = S_STEP;
      S_STEP:  state_d = S_FIN;
      S_FIN:   state_d = S_WAKE;
      S_WAKE:  state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // clean-slate product: 10 * period fits in 34 bits
  logic [63:0] clean;
  assign clean = now_q + {30'd0, period_q, 3'b000} + {33'd0, period_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      period_q  <= 30'd16666667;
      offset_q  <= 30'd4000000;
      cinit_q   <= 30'd1666667;
      cmax_q    <= 30'd5000000;
      adjm_q    <= 30'd666667;
      adjn_q    <= 30'd333333;
      mtgt_q    <= 30'd1000000;
      budget_q  <= 64'd1666667;
      next_id_q <= '0;
      done_q    <= 1'b0;
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        slot_id_q[i] <= '0;
        slot_ph_q[i] <= PH_CLEARED;
      end
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_OUT);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PERIOD:  period_q <= cfg_data_i;
          REG_OFFSET:  offset_q <= cfg_data_i;
          REG_CINIT: begin
            cinit_q  <= cfg_data_i;
            budget_q <= {34'd0, cfg_data_i};
          end
          REG_CMAX:    cmax_q   <= cfg_data_i;
          REG_ADJMISS: adjm_q   <= cfg_data_i;
          REG_ADJNON:  adjn_q   <= cfg_data_i;
          REG_MARGIN:  mtgt_q   <= cfg_data_i;
          default: ;
        endcase
      end
      // unused function codes leave the slot alone
      if (state_q == S_MARK && id_match && func_q <= FUNC_SUBMIT)
        slot_ph_q[fslot] <= func_q + 3'd1;
      if (state_q == S_INFO && id_match) begin
        slot_ph_q[fslot] <= PH_INFO;
        budget_q <= bud_new;
      end
      if (state_q == S_WAKE) begin
        slot_id_q[nslot] <= next_id_q;
        slot_ph_q[nslot] <= PH_PREDICTED;
        next_id_q <= next_id_q + 63'd1;
      end
    end
  end

  // payload, slot times and datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        func_q <= func_i; fid_q <= frame_id_i; now_q <= now_time_i;
        act_q <= actual_present_i; ep_q <= earliest_present_i;
        mar_q <= reported_margin_i;
        cnt_q <= CW'(1); lp_f_q <= 1'b0; lc_f_q <= 1'b0;
        lp_q <= '0; lc_q <= '0;
      end
      S_SRCH: if (search_ok) begin
        // scan one slot per cycle, newest first
        if (!lp_f_q && slot_ph_q[sslot] >= PH_PREDICTED && slot_id_q[sslot] == sid) begin
          lp_f_q <= 1'b1; lp_q <= sslot;
        end
        if (!lc_f_q && slot_ph_q[sslot] >= PH_INFO && slot_id_q[sslot] == sid) begin
          lc_f_q <= 1'b1; lc_q <= sslot;
        end
        cnt_q <= cnt_q + CW'(1);
      end
      S_TOTAL: total_q <= alu_res;
      S_LIMIT: begin
        limit_q <= alu_res;
        d_q     <= clean;
      end
      S_BASE: begin
        priority if (lc_f_q && lp_f_q && lc_q == lp_q) base_q <= slot_ep_q[lc_q];
        else if (lc_f_q) base_q <= slot_ep_q[lc_q] + 64'(dprod);
        else base_q <= slot_pd_q[lp_q];
      end
      S_D: d_q <= alu_res;
      S_GAP: begin
        gap_q <= alu_res; rem_q <= '0; bit_q <= 7'd63;
      end
      S_DIV: begin
        // restoring remainder of gap by the period, one bit per cycle
        if (!alu_c) rem_q <= alu_res;
        else rem_q <= {rem_q[62:0], gap_q[63]};
        gap_q  <= {gap_q[62:0], 1'b0};
        if (bit_q != 7'd0) bit_q <= bit_q - 7'd1;
        // d + (gap / p + 1) * p equals limit + (p - gap mod p)
        else acc_q <= per1 - (alu_c ? {rem_q[62:0], gap_q[63]} : alu_res);
      end
      S_STEP: d_q <= alu_res;
      S_FIN: pd_q <= alu_res;
      S_WAKE: begin
        wake_q <= alu_res;
        slot_des_q[nslot] <= d_q;
        slot_pd_q[nslot]  <= pd_q;
      end
      S_INFO: if (id_match) slot_ep_q[fslot] <= ep_q;
      default: ;
    endcase
    if (state_q == S_OUT) begin
      if (func_q == FUNC_PREDICT) begin
        acc_out_q <= acc_q_ok; oid_q <= next_id_q - 63'd1; des_q <= d_q;
        oper_q <= period_q; oslop_q <= HALF_MS;
      end else begin
        acc_out_q <= (func_q <= FUNC_INFO) && id_match;
        oid_q <= '0; des_q <= '0; oper_q <= '0; oslop_q <= '0;
        wake_q <= '0; pd_q <= '0;
      end
    end
  end

  assign busy_o                   = (state_q != S_IDLE) || done_q;
  assign done_o                   = done_q;
  assign accepted_o               = acc_out_q;
  assign issued_frame_id_o        = oid_q;
  assign wake_up_time_o           = wake_q;
  assign desired_present_time_o   = des_q;
  assign predicted_display_time_o = pd_q;
  assign display_period_o         = oper_q;
  assign present_slop_o           = oslop_q;
endmodule

### design/fpp_alu.sv
// Shared 64-bit adder/subtractor used by the add and subtract steps of the sequencer.
// Depends on fpp_pkg.
module fpp_alu import fpp_pkg::*; (
  input  alu_req_t    req_i,
  output logic [63:0] res_o,
  output logic        carry_o
);
  logic [64:0] sum;
  always_comb begin
    unique case (req_i.op)
      ALU_ADD: sum = {1'b0, req_i.a} + {1'b0, req_i.b};
      ALU_SUB: sum = {1'b0, req_i.a} - {1'b0, req_i.b};
      default: sum = '0;
    endcase
  end
  assign res_o   = sum[63:0];
  assign carry_o = sum[64];
endmodule

### design/fpp_checker.sv
// Port-level checker for the frame pacing predictor, bound to the top level.
// Depends on frame_pacing_predictor ports only.
module fpp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic accepted_o,
  input logic [29:0] present_slop_o
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy not raised");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !accepted_o |-> present_slop_o == 30'd0) else $error("slop on reject");
endmodule

bind frame_pacing_predictor fpp_checker u_fpp_checker (.*);
